// ===== hw/rtl/pmb_pkg.sv =====
// ----------------------------------------------------------------------------
// pmb_pkg
// shared types and constants of the peak meter ballistics block
// ----------------------------------------------------------------------------
package pmb_pkg;

   localparam int LEVEL_BITS_DEFAULT = 24;
   localparam int QUEUE_DEPTH        = 2;

   // register indexes of the configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FALLOFF_RATE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TIME    = 2'd1;

   localparam logic [15:0] FALLOFF_RATE_RESET = 16'd1280;
   localparam logic [15:0] HOLD_TIME_RESET    = 16'd4000;

   // operation codes
   localparam logic OP_APPLY = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // meter range in 1/64 dB
   localparam logic signed [15:0] DB_FLOOR = -16'sd20352;
   localparam logic signed [15:0] DB_CEIL  = 16'sd12800;

   // elapsed time cap in microseconds
   localparam logic [19:0] US_CAP = 20'd1000000;

   typedef struct packed {
      logic        op;
      logic [23:0] peak_level;
      logic [23:0] elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [15:0] level_db;
      logic signed [15:0] held_db;
      logic [15:0]        hold_left_ms;
      logic               clip_flag;
   } rsp_type;

   // decoded item between front and back
   typedef struct packed {
      logic               op;
      logic               zero;    // magnitude is zero
      logic               clip;    // magnitude at or above full scale
      logic signed [6:0]  expo;    // top bit index minus full-scale index
      logic [31:0]        mant;    // normalized mantissa, q1.31
      logic [19:0]        us;      // capped elapsed time
   } cmd_type;

   typedef struct packed {
      logic [15:0] falloff_rate;
      logic [15:0] hold_time_ms;
   } csr_type;

endpackage

// ===== hw/rtl/pmb_fifo.sv =====
// ----------------------------------------------------------------------------
// pmb_fifo
// small register queue with first-word fall-through read
// ----------------------------------------------------------------------------
module pmb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hw/rtl/pmb_front.sv =====
// ----------------------------------------------------------------------------
// pmb_front
// decodes one request beat: masking, clip test, normalization, time cap
// ----------------------------------------------------------------------------
module pmb_front #(
   parameter int LEVEL_BITS = 24
) (
   input  pmb_pkg::req_type req,
   output pmb_pkg::cmd_type cmd
);
   import pmb_pkg::*;

   localparam int FS = LEVEL_BITS - 2;

   logic [23:0] x;
   logic [4:0]  top;
   logic        clip;

   always_comb begin
      x    = '0;
      top  = '0;
      clip = 1'b0;
      for (int i = 0; i < 24; i++) begin
         x[i] = req.peak_level[i] && (i < LEVEL_BITS);
      end
      for (int i = 0; i < 24; i++) begin
         if (x[i]) begin
            top = 5'(i);
         end
         if (i >= FS) begin
            clip = clip | x[i];
         end
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.op   = req.op;
      cmd.zero = (x == '0);
      cmd.clip = clip;
      cmd.expo = $signed(7'(top)) - $signed(7'(FS));
      cmd.mant = {8'b0, x} << (5'd31 - top);
      cmd.us   = (req.elapsed_us > 24'(US_CAP)) ? US_CAP : req.elapsed_us[19:0];
   end

endmodule

// ===== hw/rtl/pmb_back.sv =====
// ----------------------------------------------------------------------------
// pmb_back
// log conversion, falloff and hold dividers, meter state update
// ----------------------------------------------------------------------------
module pmb_back (
   input  logic             clock,
   input  logic             reset,
   input  pmb_pkg::csr_type csr,
   input  pmb_pkg::cmd_type cmd,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output pmb_pkg::rsp_type rsp,
   input  logic             rsp_full,
   output logic             rsp_push
);
   import pmb_pkg::*;

   localparam int          LOG_STEPS = 24;
   localparam logic [28:0] K_DB64    = 29'd404035621;   // 64*20*log10(2), q.20
   // reciprocals, applied after the divisors' factors of two are shifted out
   localparam logic [30:0] DEC_RECIP = 31'd1125899907;  // 2^44 / 15625, rounded up
   localparam logic [17:0] MS_RECIP  = 18'd134218;      // 2^24 / 125, rounded up

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_LOAD  = 7'b0000010,
      S_LOG   = 7'b0000100,
      S_MUL   = 7'b0001000,
      S_SUM   = 7'b0010000,
      S_LEVEL = 7'b0100000,
      S_HOLD  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic               clear_ff, clear_in;
   logic               zero_ff, zero_in;
   logic               clip_ff, clip_in;
   logic signed [6:0]  expo_ff, expo_in;
   logic [31:0]        mant_ff, mant_in;
   logic [23:0]        frac_ff, frac_in;
   logic [19:0]        us_ff, us_in;
   logic [35:0]        rem_dec_ff, rem_dec_in;
   logic [15:0]        q_dec_ff, q_dec_in;
   logic [19:0]        rem_ms_ff, rem_ms_in;
   logic [9:0]         q_ms_ff, q_ms_in;
   logic signed [36:0] prod_hi_ff, prod_hi_in;
   logic [52:0]        prod_lo_ff, prod_lo_in;
   logic signed [16:0] db_ff, db_in;
   logic signed [15:0] level_ff, level_in;
   logic signed [15:0] held_ff, held_in;
   logic [15:0]        count_ff, count_in;
   logic               latch_ff, latch_in;

   logic [63:0]        sq;
   logic [59:0]        dec_prod;
   logic [33:0]        ms_prod;
   logic signed [61:0] p_sum;
   logic signed [17:0] lvl_a, lvl_b, lvl_c;
   logic               rearm;
   logic signed [15:0] h_arm;
   logic [15:0]        c_arm;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      clear_in   = clear_ff;
      zero_in    = zero_ff;
      clip_in    = clip_ff;
      expo_in    = expo_ff;
      mant_in    = mant_ff;
      frac_in    = frac_ff;
      us_in      = us_ff;
      rem_dec_in = rem_dec_ff;
      q_dec_in   = q_dec_ff;
      rem_ms_in  = rem_ms_ff;
      q_ms_in    = q_ms_ff;
      prod_hi_in = prod_hi_ff;
      prod_lo_in = prod_lo_ff;
      db_in      = db_ff;
      level_in   = level_ff;
      held_in    = held_ff;
      count_in   = count_ff;
      latch_in   = latch_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp        = '0;
      sq         = '0;
      dec_prod   = '0;
      ms_prod    = '0;
      p_sum      = '0;
      lvl_a      = '0;
      lvl_b      = '0;
      lvl_c      = '0;
      rearm      = 1'b0;
      h_arm      = held_ff;
      c_arm      = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               clear_in = (cmd.op == OP_CLEAR);
               zero_in  = cmd.zero;
               clip_in  = cmd.clip;
               expo_in  = cmd.expo;
               mant_in  = cmd.mant;
               us_in    = cmd.us;
               state_in = (cmd.op == OP_CLEAR) ? S_HOLD : S_LOAD;
            end
         end
         S_LOAD: begin
            rem_dec_in = 36'(csr.falloff_rate * us_ff) + 36'd500000;
            q_dec_in   = '0;
            rem_ms_in  = us_ff + 20'd500;
            q_ms_in    = '0;
            frac_in    = '0;
            step_in    = '0;
            state_in   = S_LOG;
         end
         S_LOG: begin
            // one squaring of the mantissa gives one bit of log2
            sq = mant_ff * mant_ff;
            if (sq[63]) begin
               mant_in = sq[63:32];
               frac_in = {frac_ff[22:0], 1'b1};
            end else begin
               mant_in = sq[62:31];
               frac_in = {frac_ff[22:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(LOG_STEPS - 1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_lo_in = frac_ff * K_DB64;
            prod_hi_in = 37'(expo_ff) * $signed({1'b0, K_DB64});
            // divide by 10^6 and by 1000: shift out the factor of two, then
            // multiply by the rounded-up reciprocal, exact over the full range
            dec_prod   = 60'(rem_dec_ff[35:6]) * 60'(DEC_RECIP);
            ms_prod    = 34'(rem_ms_ff[19:3]) * 34'(MS_RECIP);
            q_dec_in   = dec_prod[59:44];
            q_ms_in    = ms_prod[33:24];
            state_in   = S_SUM;
         end
         S_SUM: begin
            // round half up to 1/64 dB
            p_sum = (62'(prod_hi_ff) <<< 24) + $signed(62'(prod_lo_ff))
                  + (62'sd1 <<< 43);
            db_in    = $signed(p_sum[60:44]);
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            lvl_a = 18'(level_ff) - $signed(18'(q_dec_ff));
            lvl_b = (lvl_a < 18'(DB_FLOOR)) ? 18'(DB_FLOOR) : lvl_a;
            if (!zero_ff && (18'(db_ff) > lvl_b)) begin
               lvl_b = 18'(db_ff);
            end
            lvl_c    = (lvl_b > 18'(DB_CEIL)) ? 18'(DB_CEIL) : lvl_b;
            level_in = $signed(lvl_c[15:0]);
            latch_in = latch_ff | clip_ff;
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (clear_ff) begin
               h_arm    = DB_FLOOR;
               c_arm    = '0;
               level_in = DB_FLOOR;
               latch_in = 1'b0;
            end else begin
               rearm = (level_ff >= held_ff) && (level_ff > DB_FLOOR);
               if (rearm) begin
                  h_arm = level_ff;
                  c_arm = csr.hold_time_ms;
               end
               // marker expiry snaps to the current level
               if (c_arm != '0) begin
                  if (c_arm <= 16'(q_ms_ff)) begin
                     c_arm = '0;
                     h_arm = level_ff;
                  end else begin
                     c_arm = c_arm - 16'(q_ms_ff);
                  end
               end
            end
            rsp.level_db     = clear_ff ? DB_FLOOR : level_ff;
            rsp.held_db      = h_arm;
            rsp.hold_left_ms = c_arm;
            rsp.clip_flag    = clear_ff ? 1'b0 : latch_ff;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               held_in  = h_arm;
               count_in = c_arm;
               state_in = S_IDLE;
            end else begin
               level_in = level_ff;
               latch_in = latch_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= DB_FLOOR;
         held_ff  <= DB_FLOOR;
         count_ff <= '0;
         latch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         held_ff  <= held_in;
         count_ff <= count_in;
         latch_ff <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      clear_ff   <= clear_in;
      zero_ff    <= zero_in;
      clip_ff    <= clip_in;
      expo_ff    <= expo_in;
      mant_ff    <= mant_in;
      frac_ff    <= frac_in;
      us_ff      <= us_in;
      rem_dec_ff <= rem_dec_in;
      q_dec_ff   <= q_dec_in;
      rem_ms_ff  <= rem_ms_in;
      q_ms_ff    <= q_ms_in;
      prod_hi_ff <= prod_hi_in;
      prod_lo_ff <= prod_lo_in;
      db_ff      <= db_in;
   end

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (level_ff >= DB_FLOOR) && (level_ff <= DB_CEIL))
      else $error("meter level left its range");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      (held_ff >= DB_FLOOR) && (held_ff <= DB_CEIL))
      else $error("hold marker left its range");

   a_log_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOG) && (step_ff == 5'(LOG_STEPS - 1)) |=> (state_ff == S_MUL))
      else $error("log iteration did not finish on time");

   a_ms_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) && !clear_ff |-> (q_ms_ff <= 10'd1000))
      else $error("elapsed ms quotient out of range");

   a_push_state: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (state_ff == S_IDLE))
      else $error("state moved after result beat");

endmodule

// ===== hw/rtl/peak_meter_ballistics_top.sv =====
// ----------------------------------------------------------------------------
// peak_meter_ballistics_top
// peak meter with dB conversion, linear-in-dB falloff, peak hold and clip
// ----------------------------------------------------------------------------
// Each request beat either applies one sample (linear peak magnitude, full
// scale 2^(LEVEL_BITS-2), plus microseconds since the previous update) or
// clears the meter; each yields exactly one result beat with the meter level
// and hold marker in 1/64 dB, the hold time left in ms and the clip latch.
// Requests enter a two-entry queue as soon as they are decoded, so the input
// side keeps taking beats while the back end works. In the back end a sample
// is picked up, the falloff product is formed, the mantissa is squared 24
// times in a single 32x32 multiplier (one log2 bit each), dB scaling runs with
// the falloff and ms quotients taken by reciprocal multiplication, then come
// rounding, level update and hold update. A clear goes from pick-up straight
// to the hold update. The log iteration sets the pace; the back end takes a
// new item only after pushing its last result into a two-entry output queue.
// Configuration writes are taken at any clock but only belong between items
// while the block is idle.
// ----------------------------------------------------------------------------
module peak_meter_ballistics_top #(
   parameter int LEVEL_BITS = pmb_pkg::LEVEL_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  push,
   output logic                                  full,
   input  pmb_pkg::req_type                      req_data,
   // result side
   output logic                                  empty,
   input  logic                                  pop,
   output pmb_pkg::rsp_type                      rsp_data,
   // configuration
   input  logic                                  csr_we,
   input  logic [pmb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [15:0]                           csr_wdata
);
   import pmb_pkg::*;

   csr_type csr_ff, csr_in;
   cmd_type cmd_dec, cmd_q;
   logic    cmd_empty, cmd_pop;
   rsp_type rsp_new;
   logic    rsp_full, rsp_push;

   // configuration registers, unknown indexes are dropped
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FALLOFF_RATE: csr_in.falloff_rate = csr_wdata;
            CSR_HOLD_TIME:    csr_in.hold_time_ms = csr_wdata;
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.falloff_rate <= FALLOFF_RATE_RESET;
         csr_ff.hold_time_ms <= HOLD_TIME_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front end: masking, clip test, normalization, time cap
   pmb_front #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_front (
      .req (req_data),
      .cmd (cmd_dec)
   );

   // decoded beats wait here so front and back stall independently
   pmb_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cmd_dec),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_q),
      .empty (cmd_empty)
   );

   // back end: log2, dB scaling, falloff, hold and clip state
   pmb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .cmd       (cmd_q),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_new),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push)
   );

   // result queue decouples the consumer from the back end
   pmb_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_new),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_data),
      .empty (empty)
   );

endmodule
